>>> src/ssui_pkg.sv
// Package for the sorted set insertion block.
// Holds operation codes, beat payload types and the cell control struct.
// No dependencies.
package ssui_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_CLEAR  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam int VALUE_W = 32;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;

   typedef struct packed {
      logic [1:0]         operation;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
      logic               last;
   } req_payload_type;

   typedef struct packed {
      logic               added;
      logic               run_added;
      logic               overflow;
      logic [COUNT_W-1:0] entry_count;
      logic [VALUE_W-1:0] read_value;
   } rsp_payload_type;

   typedef struct packed {
      logic cmp_en;
      logic wr_en;
   } cell_ctrl_type;

endpackage

>>> src/ssui_chan_if.sv
// Valid/ready channel interface carrying one payload per beat.
// The payload type is a parameter; used with the types of ssui_pkg.
interface ssui_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> src/ssui_cell.sv
// One cell of the sorted set chain: holds one entry and its compare flags.
// Takes the entry of its lower neighbor on a shifting insert. Uses ssui_pkg.
module ssui_cell #(
   parameter int POS   = 0,
   parameter int CNT_W = 7
) (
   input  logic                         clock,
   input  ssui_pkg::cell_ctrl_type      ctrl,
   input  logic [ssui_pkg::VALUE_W-1:0] cmp_val,
   input  logic [ssui_pkg::INDEX_W-1:0] rd_index,
   input  logic [ssui_pkg::VALUE_W-1:0] wr_val,
   input  logic [CNT_W-1:0]             count,
   input  logic [ssui_pkg::VALUE_W-1:0] prev_entry,
   input  logic                         prev_lt,
   input  logic                         prev_occ,
   output logic [ssui_pkg::VALUE_W-1:0] entry,
   output logic                         lt,
   output logic                         occ,
   output logic                         eq,
   output logic                         hit,
   output logic                         load_new
);

   logic [ssui_pkg::VALUE_W-1:0] entry_ff;
   logic                         lt_ff;
   logic                         eq_ff;
   logic                         hit_ff;

   assign occ = int'(count) > POS;

   // The new value lands in the first cell above it, or in the first free cell.
   assign load_new = ctrl.wr_en && !prev_lt && (lt_ff || (!occ && prev_occ));

   always_ff @(posedge clock) begin
      if (ctrl.cmp_en) begin
         lt_ff  <= occ && (cmp_val < entry_ff);
         eq_ff  <= occ && (cmp_val == entry_ff);
         hit_ff <= occ && (int'(rd_index) == POS);
      end
      if (ctrl.wr_en && prev_lt) begin
         entry_ff <= prev_entry;
      end else if (load_new) begin
         entry_ff <= wr_val;
      end
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;
   assign hit   = hit_ff;

endmodule

>>> src/sorted_set_union_insert.sv
// Sorted set of distinct 32-bit values with duplicate-free insertion.
// Only one request is held at a time: requests are taken only in the idle state.
// The cells register their compare flags when a request is accepted, and shift or
// write at commit, once the response register is free; the result beat is registered then.
// Reset clears the entry count, the run flag and the handshake state; entries
// themselves are not cleared. Depends on ssui_pkg, ssui_chan_if and ssui_cell.
module sorted_set_union_insert #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   ssui_chan_if.sink   req_chan,
   ssui_chan_if.source rsp_chan
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_CMT  = 1'b1;

   logic                         state_ff;
   logic                         state_in;
   logic [CNT_W-1:0]             count_ff;
   logic [CNT_W-1:0]             count_in;
   logic                         run_ff;
   logic                         run_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   ssui_pkg::rsp_payload_type    rsp_data_ff;
   ssui_pkg::rsp_payload_type    rsp_data_in;
   logic [1:0]                   op_ff;
   logic [ssui_pkg::VALUE_W-1:0] val_ff;
   logic                         last_ff;

   ssui_pkg::cell_ctrl_type      ctrl;
   logic                         req_fire;
   logic                         commit;
   logic                         match;
   logic                         full;
   logic                         do_add;
   logic [ssui_pkg::VALUE_W-1:0] rd_word;

   logic [ssui_pkg::VALUE_W-1:0] entry_vec [CAPACITY];
   logic [CAPACITY-1:0]          lt_vec;
   logic [CAPACITY-1:0]          occ_vec;
   logic [CAPACITY-1:0]          eq_vec;
   logic [CAPACITY-1:0]          hit_vec;
   logic [CAPACITY-1:0]          load_vec;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign commit         = (state_ff == ST_CMT) && (!rsp_valid_ff || rsp_chan.ready);

   assign match  = |eq_vec;
   assign full   = (int'(count_ff) >= CAPACITY);
   assign do_add = (op_ff == ssui_pkg::OP_INSERT) && !match && !full;

   assign ctrl.cmp_en = req_fire;
   assign ctrl.wr_en  = commit && do_add;

   for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
      logic [ssui_pkg::VALUE_W-1:0] prev_entry;
      logic                         prev_lt;
      logic                         prev_occ;
      if (j == 0) begin : g_first
         assign prev_entry = '0;
         assign prev_lt    = 1'b0;
         assign prev_occ   = 1'b1;
      end else begin : g_next
         assign prev_entry = entry_vec[j-1];
         assign prev_lt    = lt_vec[j-1];
         assign prev_occ   = occ_vec[j-1];
      end
      ssui_cell #(
         .POS   (j),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cmp_val    (req_chan.payload.value),
         .rd_index   (req_chan.payload.index),
         .wr_val     (val_ff),
         .count      (count_ff),
         .prev_entry (prev_entry),
         .prev_lt    (prev_lt),
         .prev_occ   (prev_occ),
         .entry      (entry_vec[j]),
         .lt         (lt_vec[j]),
         .occ        (occ_vec[j]),
         .eq         (eq_vec[j]),
         .hit        (hit_vec[j]),
         .load_new   (load_vec[j])
      );
   end

   always_comb begin
      rd_word = '0;
      for (int j = 0; j < CAPACITY; j++) begin
         rd_word = rd_word | (hit_vec[j] ? entry_vec[j] : '0);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      run_in       = run_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         state_in = ST_CMT;
      end
      if (commit) begin
         state_in    = ST_IDLE;
         rsp_data_in = '0;
         case (op_ff)
            ssui_pkg::OP_INSERT: begin
               if (do_add) begin
                  count_in = count_ff + CNT_W'(1);
               end
               rsp_data_in.added    = do_add;
               rsp_data_in.overflow = !match && full;
               run_in               = run_ff || do_add;
               if (last_ff) begin
                  rsp_data_in.run_added = run_ff || do_add;
                  run_in                = 1'b0;
               end
            end
            ssui_pkg::OP_CLEAR: begin
               count_in = '0;
               run_in   = 1'b0;
            end
            ssui_pkg::OP_READ: begin
               rsp_data_in.read_value = rd_word;
            end
            default: begin
            end
         endcase
         rsp_data_in.entry_count = ssui_pkg::COUNT_W'(count_in);
         rsp_valid_in            = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_fire) begin
         op_ff   <= req_chan.payload.operation;
         val_ff  <= req_chan.payload.value;
         last_ff <= req_chan.payload.last;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= CAPACITY)
      else $error("entry count exceeds capacity");

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0(load_vec))
      else $error("more than one cell loads the new value");

   a_distinct: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMT) |-> $onehot0(eq_vec))
      else $error("value matches more than one held entry");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_CMT))
      else $error("response beat raised without a commit");
`endif

endmodule
